@@ rtl/core/gprb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register block package
// Shared types, register indexes and reset values of the GPIO port block.
// ----------------------------------------------------------------------------
package gprb_pkg;

	localparam int REG_COUNT = 10;
	localparam int REG_IDX_W = 4;

	localparam logic [REG_IDX_W-1:0] IDX_MODE  = 4'd0;
	localparam logic [REG_IDX_W-1:0] IDX_SPEED = 4'd2;
	localparam logic [REG_IDX_W-1:0] IDX_PULL  = 4'd3;
	localparam logic [REG_IDX_W-1:0] IDX_IDR   = 4'd4;
	localparam logic [REG_IDX_W-1:0] IDX_ODR   = 4'd5;
	localparam logic [REG_IDX_W-1:0] IDX_BSR   = 4'd6;

	localparam logic [31:0] IDR_RESET  = 32'h0000_ffff;
	localparam logic [31:0] V0_MODE    = 32'ha800_0000;
	localparam logic [31:0] V0_PULL    = 32'h6400_0000;
	localparam logic [31:0] V1_MODE    = 32'h0000_0280;
	localparam logic [31:0] V1_SPEED   = 32'h0000_00C0;
	localparam logic [31:0] V1_PULL    = 32'h0000_0100;
	localparam logic [31:0] BYTE_MASK  = 32'h0000_00ff;
	localparam logic [31:0] HALF_MASK  = 32'h0000_ffff;

	typedef enum logic [1:0] {
		FUNC_READ      = 2'd0,
		FUNC_WRITE     = 2'd1,
		FUNC_PIN_EVENT = 2'd2,
		FUNC_NONE      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2,
		SIZE_WIDE = 2'd3
	} size_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  byte_address;
		logic [1:0]  access_size;
		logic [31:0] write_data;
		logic [3:0]  pin_index;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] pin_levels;
		logic [15:0] pin_changed;
		logic        exti_valid;
		logic [3:0]  exti_pin;
		logic        exti_level;
		logic        access_error;
	} out_item_t;

	function automatic logic [31:0] reset_value(input int variant, input int idx);
		logic [31:0] v;
		v = '0;
		if (idx == int'(IDX_IDR)) begin
			v = IDR_RESET;
		end else if (variant == 0) begin
			if (idx == int'(IDX_MODE)) v = V0_MODE;
			if (idx == int'(IDX_PULL)) v = V0_PULL;
		end else if (variant == 1) begin
			if (idx == int'(IDX_MODE))  v = V1_MODE;
			if (idx == int'(IDX_SPEED)) v = V1_SPEED;
			if (idx == int'(IDX_PULL))  v = V1_PULL;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/gprb_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port input stage
// Registers each accepted transfer and holds it until the execute step takes it.
// ----------------------------------------------------------------------------
module gprb_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire gprb_pkg::in_item_t in_item,
	input  wire                 advance,
	output logic                valid_s1,
	output gprb_pkg::in_item_t  item_s1
);
	import gprb_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gprb_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port execute stage
// Holds the register file and performs the read, merge-write or pin update.
// ----------------------------------------------------------------------------
module gprb_exec #(
	parameter int PIN_COUNT    = 16,
	parameter int PORT_VARIANT = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  wire gprb_pkg::in_item_t item_s1,
	output gprb_pkg::out_item_t result
);
	import gprb_pkg::*;

	localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

	logic [31:0] rf_q [REG_COUNT];

	logic [7:0]           idx_full;
	logic [REG_IDX_W-1:0] idx;
	logic [1:0]           lane;
	logic                 in_range;
	logic [31:0]          cur;
	logic [31:0]          lane_mask;
	logic [31:0]          size_mask;
	logic [31:0]          merged;
	logic [15:0]          odr;
	logic [15:0]          odr_next;
	logic [31:0]          idr_next;
	logic [31:0]          pin_bit;
	logic                 pin_ok;
	logic                 do_write;
	logic                 do_odr;
	logic                 do_store;
	logic                 do_pin;

	assign idx_full = item_s1.byte_address[9:2];
	assign idx      = idx_full[REG_IDX_W-1:0];
	assign lane     = item_s1.byte_address[1:0];
	assign in_range = idx_full < 8'(REG_COUNT);
	assign cur      = in_range ? rf_q[idx] : '0;
	assign odr      = rf_q[IDX_ODR][15:0];

	always_comb begin
		case (size_t'(item_s1.access_size))
			SIZE_BYTE: size_mask = BYTE_MASK;
			SIZE_HALF: size_mask = HALF_MASK;
			default:   size_mask = '1;
		endcase
		lane_mask = size_mask << {lane, 3'b000};
		if (size_mask == '1) begin
			merged = item_s1.write_data;
		end else begin
			merged = (cur & ~lane_mask) | ((item_s1.write_data & size_mask) << {lane, 3'b000});
		end
	end

	assign pin_ok  = int'(item_s1.pin_index) < PIN_COUNT;
	assign pin_bit = 32'd1 << item_s1.pin_index;
	assign idr_next = item_s1.pin_level ? (rf_q[IDX_IDR] | pin_bit) : (rf_q[IDX_IDR] & ~pin_bit);

	assign do_write = (func_t'(item_s1.func) == FUNC_WRITE) && in_range;
	assign do_odr   = do_write && (idx == IDX_ODR || idx == IDX_BSR);
	assign do_store = do_write && !do_odr;
	assign do_pin   = (func_t'(item_s1.func) == FUNC_PIN_EVENT) && pin_ok;

	always_comb begin
		odr_next = odr;
		if (do_odr) begin
			if (idx == IDX_BSR) begin
				odr_next = (odr & ~merged[31:16]) | merged[15:0];
			end else begin
				odr_next = merged[15:0];
			end
		end
	end

	always_comb begin
		result              = '0;
		result.pin_levels   = odr_next & PIN_MASK;
		result.pin_changed  = (odr ^ odr_next) & PIN_MASK;
		result.access_error = !in_range &&
			(func_t'(item_s1.func) == FUNC_READ || func_t'(item_s1.func) == FUNC_WRITE);
		if (func_t'(item_s1.func) == FUNC_READ && in_range) begin
			result.read_data = cur;
		end
		if (do_pin) begin
			result.exti_valid = 1'b1;
			result.exti_pin   = item_s1.pin_index;
			result.exti_level = item_s1.pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= reset_value(PORT_VARIANT, i);
			end
		end else if (fire) begin
			if (do_store) begin
				rf_q[idx] <= merged;
			end
			if (do_odr) begin
				rf_q[IDX_ODR] <= {16'h0000, odr_next};
			end
			if (do_pin) begin
				rf_q[IDX_IDR] <= idr_next;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gpio_port_register_block_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register block
// Ten 32-bit GPIO registers with byte-lane writes, bit set/reset and pin events.
// ----------------------------------------------------------------------------
// One transfer is accepted per cycle while the result register is free or
// being taken (out_ready), and each gives one result: the transfer is registered
// in the input stage, then a read-modify-write on the register file produces the
// result register. Throughput is set by that update, one access per clock.
module gpio_port_register_block_core #(
	parameter int PIN_COUNT    = 16,
	parameter int PORT_VARIANT = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire gprb_pkg::in_item_t in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output gprb_pkg::out_item_t  out_item
);
	import gprb_pkg::*;

	logic      advance;
	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result;

	assign advance = !out_valid || out_ready;

	gprb_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gprb_exec #(
		.PIN_COUNT    (PIN_COUNT),
		.PORT_VARIANT (PORT_VARIANT)
	) u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_item <= result;
		end
	end

endmodule
`default_nettype wire

@@ dv/gpio_port_register_block_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port register block testbench
// Sends bus reads, byte/halfword/word writes and pin events to the block. A
// behavioural copy of the register file predicts every result, and each
// result transfer is compared field by field with the oldest prediction.
// Both handshakes are throttled at random, with one pause that lets the block
// drain completely.
// ----------------------------------------------------------------------------
module gpio_port_register_block_core_test;
	import gprb_pkg::*;

	localparam int PINS    = 16;
	localparam int VARIANT = 2;
	localparam logic [15:0] PIN_MASK = 16'((32'd1 << PINS) - 1);
	localparam int RANDOM_ITEMS = 1950;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;

	logic [31:0] port_regs [0:REG_COUNT-1];
	out_item_t   expected_responses [$];
	int          error_count = 0;
	int          burst_left = 0;
	int          ready_mode = 0;
	int          mode_cycles = 0;

	gpio_port_register_block_core #(
		.PIN_COUNT    (PINS),
		.PORT_VARIANT (VARIANT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_error(input string msg);
		if (error_count < 100) begin
			$display("%0t ns: %s", $time, msg);
		end
		error_count++;
	endtask

	task automatic reset_port_model();
		for (int i = 0; i < REG_COUNT; i++) begin
			port_regs[i] = '0;
		end
		if (VARIANT == 0) begin
			port_regs[IDX_MODE] = V0_MODE;
			port_regs[IDX_PULL] = V0_PULL;
		end else if (VARIANT == 1) begin
			port_regs[IDX_MODE]  = V1_MODE;
			port_regs[IDX_SPEED] = V1_SPEED;
			port_regs[IDX_PULL]  = V1_PULL;
		end
		port_regs[IDX_IDR] = IDR_RESET;
	endtask

	function automatic logic [15:0] drive_pins(input logic [31:0] value);
		logic [15:0] changed;
		changed = (port_regs[IDX_ODR][15:0] ^ value[15:0]) & PIN_MASK;
		port_regs[IDX_ODR] = value & HALF_MASK;
		return changed;
	endfunction

	function automatic out_item_t predict_port_response(input in_item_t it);
		out_item_t   r;
		logic [7:0]  idx;
		logic [1:0]  lane;
		logic [31:0] width_mask;
		logic [63:0] lane_mask;
		logic [63:0] lane_data;
		logic [31:0] merged;
		logic [31:0] next_odr;
		r = '0;
		idx = it.byte_address[9:2];
		lane = it.byte_address[1:0];
		case (it.func)
			FUNC_READ: begin
				if (idx < REG_COUNT) begin
					r.read_data = port_regs[idx];
				end else begin
					r.access_error = 1'b1;
				end
			end
			FUNC_WRITE: begin
				if (idx >= REG_COUNT) begin
					r.access_error = 1'b1;
				end else begin
					if (it.access_size == SIZE_BYTE || it.access_size == SIZE_HALF) begin
						width_mask = (it.access_size == SIZE_BYTE) ? BYTE_MASK : HALF_MASK;
						lane_mask = {32'b0, width_mask} << (lane * 8);
						lane_data = {32'b0, it.write_data & width_mask} << (lane * 8);
						merged = (port_regs[idx] & ~lane_mask[31:0]) | lane_data[31:0];
					end else begin
						merged = it.write_data;
					end
					if (idx == IDX_ODR) begin
						r.pin_changed = drive_pins(merged);
					end else if (idx == IDX_BSR) begin
						next_odr = port_regs[IDX_ODR] & HALF_MASK;
						next_odr &= ~(merged >> 16);
						next_odr |= merged & HALF_MASK;
						r.pin_changed = drive_pins(next_odr);
					end else begin
						port_regs[idx] = merged;
					end
				end
			end
			FUNC_PIN_EVENT: begin
				if (it.pin_index < PINS) begin
					port_regs[IDX_IDR][it.pin_index] = it.pin_level;
					r.exti_valid = 1'b1;
					r.exti_pin = it.pin_index;
					r.exti_level = it.pin_level;
				end
			end
			default: begin
			end
		endcase
		r.pin_levels = port_regs[IDX_ODR][15:0] & PIN_MASK;
		return r;
	endfunction

	function automatic in_item_t make_item(input func_t func, input int addr,
			input size_t size, input logic [31:0] data, input int pin, input bit level);
		in_item_t it;
		it.func = func;
		it.byte_address = 10'(addr);
		it.access_size = size;
		it.write_data = data;
		it.pin_index = 4'(pin);
		it.pin_level = level;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		expected_responses.push_back(predict_port_response(it));
	endtask

	task automatic wait_until_drained(input int extra_cycles);
		int waited;
		waited = 0;
		while (expected_responses.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_responses.size() == 0) begin
				report_error("result transfer with no prediction outstanding");
			end else begin
				want = expected_responses.pop_front();
				check_field("read_data", out_item.read_data, want.read_data);
				check_field("pin_levels", out_item.pin_levels, want.pin_levels);
				check_field("pin_changed", out_item.pin_changed, want.pin_changed);
				check_field("exti_valid", out_item.exti_valid, want.exti_valid);
				check_field("exti_pin", out_item.exti_pin, want.exti_pin);
				check_field("exti_level", out_item.exti_level, want.exti_level);
				check_field("access_error", out_item.access_error, want.access_error);
			end
		end
	end

	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_cycles = $urandom_range(16, 128);
		end
		mode_cycles--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (mode_cycles % 3 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic test_reset_values();
		send_item(make_item(FUNC_READ, IDX_MODE * 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_READ, IDX_PULL * 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_READ, IDX_IDR * 4, SIZE_WORD, '0, 0, 1'b0));
	endtask

	task automatic test_byte_lanes();
		send_item(make_item(FUNC_WRITE, 4 + 3, SIZE_BYTE, 32'hffff_ffa5, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, IDX_SPEED * 4 + 3, SIZE_HALF, 32'h1234_5678, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, IDX_SPEED * 4 + 1, SIZE_HALF, 32'hffff_c3d2, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, 9 * 4, SIZE_WIDE, 32'hdead_beef, 0, 1'b0));
		send_item(make_item(FUNC_READ, 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_READ, IDX_SPEED * 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_READ, 9 * 4, SIZE_WORD, '0, 0, 1'b0));
	endtask

	task automatic test_output_drive();
		send_item(make_item(FUNC_WRITE, IDX_ODR * 4, SIZE_WORD, 32'hffff_ffff, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, IDX_BSR * 4, SIZE_WORD, 32'hffff_ffff, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, IDX_BSR * 4, SIZE_WORD, 32'h8001_0000, 0, 1'b0));
		send_item(make_item(FUNC_READ, IDX_BSR * 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_READ, IDX_ODR * 4, SIZE_WORD, '0, 0, 1'b0));
	endtask

	task automatic test_pin_events();
		send_item(make_item(FUNC_PIN_EVENT, 0, SIZE_BYTE, '0, 15, 1'b0));
		send_item(make_item(FUNC_PIN_EVENT, 0, SIZE_BYTE, '0, 0, 1'b1));
		send_item(make_item(FUNC_READ, IDX_IDR * 4, SIZE_WORD, '0, 0, 1'b0));
	endtask

	task automatic test_out_of_range();
		send_item(make_item(FUNC_READ, REG_COUNT * 4, SIZE_WORD, '0, 0, 1'b0));
		send_item(make_item(FUNC_WRITE, 1023, SIZE_WORD, 32'hffff_ffff, 0, 1'b0));
		send_item(make_item(FUNC_NONE, 0, SIZE_WORD, 32'hffff_ffff, 15, 1'b1));
		send_item(make_item(FUNC_READ, 1020, SIZE_WORD, '0, 0, 1'b0));
	endtask

	task automatic test_random_traffic(input int count);
		in_item_t it;
		int       pick;
		int       idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				it.func = FUNC_WRITE;
			end else if (pick < 60) begin
				it.func = FUNC_READ;
			end else if (pick < 92) begin
				it.func = FUNC_PIN_EVENT;
			end else begin
				it.func = FUNC_NONE;
			end
			if ($urandom_range(0, 99) < 8) begin
				it.byte_address = 10'($urandom_range(0, 1023));
			end else begin
				idx = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? IDX_ODR : IDX_BSR)
					: $urandom_range(0, REG_COUNT - 1);
				it.byte_address = 10'(idx * 4 + $urandom_range(0, 3));
			end
			it.access_size = 2'($urandom_range(0, 3));
			it.write_data = $urandom;
			if ($urandom_range(0, 1)) begin
				if (it.access_size == SIZE_BYTE) begin
					it.write_data &= BYTE_MASK;
				end else if (it.access_size == SIZE_HALF) begin
					it.write_data &= HALF_MASK;
				end
			end
			it.pin_index = 4'($urandom_range(0, 15));
			it.pin_level = 1'($urandom_range(0, 1));
			send_item(it);
		end
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait_until_drained(0);
		burst_left = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		reset_port_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_byte_lanes();
		test_output_drive();
		test_pin_events();
		test_out_of_range();
		test_random_traffic(RANDOM_ITEMS / 2);
		test_drain_pause();
		test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

		in_valid <= 1'b0;
		wait_until_drained(20);
		if (expected_responses.size() != 0) begin
			report_error($sformatf("%0d predicted results never arrived",
				expected_responses.size()));
		end
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
